@@ src/windowed_rms_meter_assert.svh @@
// Assertion macros shared by the RMS meter RTL.
`ifndef WINDOWED_RMS_METER_ASSERT_SVH
`define WINDOWED_RMS_METER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rms_pkg.sv @@
// Package: widths, microcode format and control program of the RMS meter.
`default_nettype none

package rms_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int MAX_SAMPLES = 4096;

    localparam int COUNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int MEAN_W    = 2 * SAMPLE_BITS;
    localparam int SUM_W     = MEAN_W + COUNT_W;
    localparam int ROOT_W    = SAMPLE_BITS;
    localparam int OFFS_W    = 12;
    localparam int GAIN_W    = 20;
    localparam int GAIN_FRAC = 16;
    localparam int PROD_W    = ROOT_W + GAIN_W;
    localparam int SCALED_W  = 16;
    localparam int CFG_W     = GAIN_W;
    localparam int CFG_IDX_W = 1;

    localparam int DIV_STEPS  = MEAN_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int ITER_W     = $clog2(DIV_STEPS);

    localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = ROOT_W + SCALED_W + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OFFS_W-1:0] OFFSET_RESET = OFFS_W'(2048);
    localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(65536);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTS_GAIN  = 1'd1;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_SQUARE,
        OP_ACCUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_SCALE,
        OP_WAIT_OUT,
        OP_EMIT
    } op_t;

    // jump is taken when the condition holds, else fall through to the next step
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NEVER,
        COND_NO_INPUT,
        COND_NOT_LAST,
        COND_ITER_MORE,
        COND_OUT_BUSY
    } cond_t;

    localparam int PC_W = 4;

    localparam logic [PC_W-1:0] STEP_WAIT      = 4'd0;
    localparam logic [PC_W-1:0] STEP_SQUARE    = 4'd1;
    localparam logic [PC_W-1:0] STEP_ACCUM     = 4'd2;
    localparam logic [PC_W-1:0] STEP_DIV_INIT  = 4'd3;
    localparam logic [PC_W-1:0] STEP_DIV       = 4'd4;
    localparam logic [PC_W-1:0] STEP_SQRT_INIT = 4'd5;
    localparam logic [PC_W-1:0] STEP_SQRT      = 4'd6;
    localparam logic [PC_W-1:0] STEP_SCALE     = 4'd7;
    localparam logic [PC_W-1:0] STEP_WAIT_OUT  = 4'd8;
    localparam logic [PC_W-1:0] STEP_EMIT      = 4'd9;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic in_fire;
    } dp_ctrl_t;

    typedef struct packed {
        logic last;
        logic iter_zero;
        logic out_busy;
    } dp_stat_t;

    // control store
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            STEP_WAIT:      w = '{OP_WAIT,      COND_NO_INPUT,  STEP_WAIT};
            STEP_SQUARE:    w = '{OP_SQUARE,    COND_NEVER,     STEP_WAIT};
            STEP_ACCUM:     w = '{OP_ACCUM,     COND_NOT_LAST,  STEP_WAIT};
            STEP_DIV_INIT:  w = '{OP_DIV_INIT,  COND_NEVER,     STEP_WAIT};
            STEP_DIV:       w = '{OP_DIV_STEP,  COND_ITER_MORE, STEP_DIV};
            STEP_SQRT_INIT: w = '{OP_SQRT_INIT, COND_NEVER,     STEP_WAIT};
            STEP_SQRT:      w = '{OP_SQRT_STEP, COND_ITER_MORE, STEP_SQRT};
            STEP_SCALE:     w = '{OP_SCALE,     COND_NEVER,     STEP_WAIT};
            STEP_WAIT_OUT:  w = '{OP_WAIT_OUT,  COND_OUT_BUSY,  STEP_WAIT_OUT};
            STEP_EMIT:      w = '{OP_EMIT,      COND_ALWAYS,    STEP_WAIT};
            default:        w = '{OP_WAIT,      COND_ALWAYS,    STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ src/rms_dp.sv @@
// Datapath of the RMS meter: accumulator, shared multiplier, divider, root, output register.
`default_nettype none
`include "windowed_rms_meter_assert.svh"

module rms_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire rms_pkg::dp_ctrl_t               ctrl,
    output rms_pkg::dp_stat_t                    stat,
    input  wire logic                            cfg_we,
    input  wire logic [rms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rms_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic [rms_pkg::SAMPLE_BITS-1:0] in_sample,
    input  wire logic                            in_last,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic [rms_pkg::ROOT_W-1:0]           out_rms_counts,
    output logic [rms_pkg::SCALED_W-1:0]         out_rms_scaled,
    output logic [rms_pkg::COUNT_W-1:0]          out_window_samples,
    output logic                                 out_count_overflow
);
    import rms_pkg::*;

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int SQR_W  = ROOT_W + 3;

    logic [OFFS_W-1:0]      zero_offset_reg, zero_offset_next;
    logic [GAIN_W-1:0]      volts_gain_reg, volts_gain_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic                   out_valid_reg, out_valid_next;

    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                   last_reg, last_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [COUNT_W-1:0]     div_rem_reg, div_rem_next;
    logic [MEAN_W-1:0]      quo_reg, quo_next;
    logic [ROOT_W:0]        sq_rem_reg, sq_rem_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic [ROOT_W-1:0]      res_root_reg, res_root_next;
    logic [SCALED_W-1:0]    res_scaled_reg, res_scaled_next;
    logic [COUNT_W-1:0]     res_count_reg, res_count_next;
    logic                   res_ovf_reg, res_ovf_next;

    logic [DIFF_W-1:0]      diff;
    logic [DIFF_W-1:0]      diff_abs;
    logic [ROOT_W-1:0]      mul_a;
    logic [GAIN_W-1:0]      mul_b;
    logic [COUNT_W:0]       div_trial;
    logic                   div_take;
    logic [SQR_W-1:0]       sq_part;
    logic [SQR_W-1:0]       sq_trial;
    logic                   sq_take;
    logic [PROD_W-1:0]      prod_shift;
    logic                   window_full;

    // offset sample magnitude; a negative difference is negated in full width
    assign diff     = {1'b0, sample_reg} - DIFF_W'(zero_offset_reg);
    assign diff_abs = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;

    // one multiplier serves the square and the gain
    always_comb
    begin
        case (ctrl.op)
            OP_SQUARE:
            begin
                mul_a = diff_abs[ROOT_W-1:0];
                mul_b = GAIN_W'(diff_abs[ROOT_W-1:0]);
            end
            default:
            begin
                mul_a = root_reg;
                mul_b = volts_gain_reg;
            end
        endcase
    end

    // restoring divide, one quotient bit a step; a zero count leaves the mean at zero
    assign div_trial = {div_rem_reg, quo_reg[MEAN_W-1]};
    assign div_take  = (count_reg != '0) && (div_trial >= {1'b0, count_reg});

    // digit-by-digit root, two radicand bits a step
    assign sq_part  = {sq_rem_reg, quo_reg[MEAN_W-1 -: 2]};
    assign sq_trial = SQR_W'({root_reg, 2'b01});
    assign sq_take  = (sq_part >= sq_trial);

    assign prod_shift  = prod_reg >> GAIN_FRAC;
    assign window_full = (count_reg == COUNT_W'(MAX_SAMPLES));

    always_comb
    begin
        zero_offset_next = zero_offset_reg;
        volts_gain_next  = volts_gain_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        iter_next        = iter_reg;
        out_valid_next   = out_valid_reg;
        sample_next      = sample_reg;
        last_next        = last_reg;
        prod_next        = prod_reg;
        div_rem_next     = div_rem_reg;
        quo_next         = quo_reg;
        sq_rem_next      = sq_rem_reg;
        root_next        = root_reg;
        res_root_next    = res_root_reg;
        res_scaled_next  = res_scaled_reg;
        res_count_next   = res_count_reg;
        res_ovf_next     = res_ovf_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ZERO_OFFSET: zero_offset_next = cfg_data[OFFS_W-1:0];
                CFG_VOLTS_GAIN:  volts_gain_next  = cfg_data[GAIN_W-1:0];
                default:         ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (ctrl.op)
            OP_WAIT:
            begin
                if (ctrl.in_fire)
                begin
                    sample_next = in_sample;
                    last_next   = in_last;
                end
            end
            OP_SQUARE, OP_SCALE:
            begin
                prod_next = PROD_W'(mul_a * mul_b);
            end
            OP_ACCUM:
            begin
                if (window_full)
                    ovf_next = 1'b1;
                else
                begin
                    sum_next   = sum_reg + SUM_W'(prod_reg[MEAN_W-1:0]);
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_DIV_INIT:
            begin
                div_rem_next = sum_reg[SUM_W-1:MEAN_W];
                quo_next     = sum_reg[MEAN_W-1:0];
                iter_next    = ITER_W'(DIV_STEPS - 1);
            end
            OP_DIV_STEP:
            begin
                div_rem_next = div_take ? COUNT_W'(div_trial - {1'b0, count_reg})
                                        : div_trial[COUNT_W-1:0];
                quo_next     = {quo_reg[MEAN_W-2:0], div_take};
                if (iter_reg != '0)
                    iter_next = iter_reg - ITER_W'(1);
            end
            OP_SQRT_INIT:
            begin
                sq_rem_next = '0;
                root_next   = '0;
                iter_next   = ITER_W'(SQRT_STEPS - 1);
            end
            OP_SQRT_STEP:
            begin
                sq_rem_next = sq_take ? (ROOT_W+1)'(sq_part - sq_trial)
                                      : sq_part[ROOT_W:0];
                root_next   = {root_reg[ROOT_W-2:0], sq_take};
                quo_next    = {quo_reg[MEAN_W-3:0], 2'b00};
                if (iter_reg != '0)
                    iter_next = iter_reg - ITER_W'(1);
            end
            OP_EMIT:
            begin
                res_root_next   = root_reg;
                res_scaled_next = (prod_shift > PROD_W'({SCALED_W{1'b1}}))
                                  ? {SCALED_W{1'b1}} : prod_shift[SCALED_W-1:0];
                res_count_next  = count_reg;
                res_ovf_next    = ovf_reg;
                out_valid_next  = 1'b1;
                sum_next        = '0;
                count_next      = '0;
                ovf_next        = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg <= OFFSET_RESET;
            volts_gain_reg  <= GAIN_RESET;
            sum_reg         <= '0;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            iter_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            zero_offset_reg <= zero_offset_next;
            volts_gain_reg  <= volts_gain_next;
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            ovf_reg         <= ovf_next;
            iter_reg        <= iter_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        last_reg       <= last_next;
        prod_reg       <= prod_next;
        div_rem_reg    <= div_rem_next;
        quo_reg        <= quo_next;
        sq_rem_reg     <= sq_rem_next;
        root_reg       <= root_next;
        res_root_reg   <= res_root_next;
        res_scaled_reg <= res_scaled_next;
        res_count_reg  <= res_count_next;
        res_ovf_reg    <= res_ovf_next;
    end

    assign stat.last      = last_reg;
    assign stat.iter_zero = (iter_reg == '0);
    assign stat.out_busy  = out_valid_reg;

    assign out_valid          = out_valid_reg;
    assign out_rms_counts     = res_root_reg;
    assign out_rms_scaled     = res_scaled_reg;
    assign out_window_samples = res_count_reg;
    assign out_count_overflow = res_ovf_reg;

    `RMS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= COUNT_W'(MAX_SAMPLES), "sample count beyond window limit")
    `RMS_ASSERT_NXT(a_emit_clears, clk, rst_n, ctrl.op == OP_EMIT, count_reg == '0 && !ovf_reg && out_valid_reg, "window state not cleared at close")
    `RMS_ASSERT_NOW(a_emit_free, clk, rst_n, ctrl.op == OP_EMIT, !out_valid_reg, "result written over an unread one")

endmodule

`default_nettype wire

@@ src/windowed_rms_meter.sv @@
// Top level of the windowed RMS meter: microcode sequencer and stream ports.
//
// Input stream s_axis: one 12-bit ADC sample per item, tlast closes the window.
// Output stream m_axis: one result per closed window: RMS in ADC counts, the
// same scaled by the Q4.16 gain, the sample count and an overflow flag.
// Configuration: cfg_we with cfg_index 0 writes the zero offset, index 1 the
// gain; write only while the meter is idle.
// A mid-window item passes the accept, square and accumulate steps; s_axis_tready is
// high only in the accept step, so a sample is not taken before the last is done.
// A closing item runs on through the divide setup, a 24-step restoring divide, the
// root setup, a 12-step root, the scale step, a wait while the output register is
// still unread, and the emit step that raises m_axis_tvalid.
// The result sits in an output register; the sequencer goes back to sampling
// at once, and only stalls at the next window close while that register is
// still unread. Everything held by m_axis_tready is the last result.
// Reset clears the sum, count and overflow flag, restores the offset to 2048
// and the gain to 1.0, and drops m_axis_tvalid.
`default_nettype none
`include "windowed_rms_meter_assert.svh"

module windowed_rms_meter (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rms_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [rms_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // sample
    input  wire logic                           s_axis_tlast,  // last_in_window
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // rms_counts, rms_scaled, window_samples
    output logic [rms_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [0:0]                          m_axis_tuser   // count_overflow
);
    import rms_pkg::*;

    logic [PC_W-1:0]     pc_reg, pc_next;
    uword_t              uw;
    logic                take;
    dp_ctrl_t            ctrl;
    dp_stat_t            stat;
    logic [ROOT_W-1:0]   rms_counts;
    logic [SCALED_W-1:0] rms_scaled;
    logic [COUNT_W-1:0]  window_samples;
    logic                count_overflow;

    assign uw = ucode(pc_reg);

    always_comb
    begin
        case (uw.cond)
            COND_ALWAYS:    take = 1'b1;
            COND_NEVER:     take = 1'b0;
            COND_NO_INPUT:  take = !s_axis_tvalid;
            COND_NOT_LAST:  take = !stat.last;
            COND_ITER_MORE: take = !stat.iter_zero;
            COND_OUT_BUSY:  take = stat.out_busy;
            default:        take = 1'b1;
        endcase
        pc_next = take ? uw.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_WAIT;
        else
            pc_reg <= pc_next;
    end

    assign s_axis_tready = (uw.op == OP_WAIT);
    assign ctrl.op       = uw.op;
    assign ctrl.in_fire  = s_axis_tvalid && s_axis_tready;

    rms_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctrl               (ctrl),
        .stat               (stat),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_sample          (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_last            (s_axis_tlast),
        .out_ready          (m_axis_tready),
        .out_valid          (m_axis_tvalid),
        .out_rms_counts     (rms_counts),
        .out_rms_scaled     (rms_scaled),
        .out_window_samples (window_samples),
        .out_count_overflow (count_overflow)
    );

    assign m_axis_tdata = OUT_DATA_W'({window_samples, rms_scaled, rms_counts});
    assign m_axis_tuser = count_overflow;

    `RMS_ASSERT_NXT(a_accept_square, clk, rst_n, s_axis_tvalid && s_axis_tready, pc_reg == STEP_SQUARE, "accepted item not squared next")
    `RMS_ASSERT_NOW(a_pc_range, clk, rst_n, 1'b1, pc_reg <= STEP_EMIT, "step counter outside program")
    `RMS_ASSERT_NOW(a_result_source, clk, rst_n, $rose(m_axis_tvalid), $past(pc_reg) == STEP_EMIT, "result raised outside emit step")

endmodule

`default_nettype wire

@@ dv/tb_windowed_rms_meter.sv @@
// Testbench for the windowed RMS meter: directed windows, random windows, a wide window.
`timescale 1ns / 100ps

module tb_windowed_rms_meter;
    import rms_pkg::*;

    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_CYCLES  = 80;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 136;
    localparam int WIDE_ITEMS    = 320;  // enough full-scale squares to pass 32 bits
    localparam int DIR_ROWS      = 25;
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

    typedef struct packed {
        logic [ROOT_W-1:0]   counts;
        logic [SCALED_W-1:0] scaled;
        logic [COUNT_W-1:0]  n;
        logic                ovf;
    } rms_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
        logic [OFFS_W-1:0]      offset;
        logic [GAIN_W-1:0]      gain;
        logic                   typed;
        rms_result_t            want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // sample
    logic                  s_axis_tlast;   // last_in_window
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // rms_counts, rms_scaled, window_samples
    logic [0:0]            m_axis_tuser;   // count_overflow

    // meter state as predicted
    logic [OFFS_W-1:0]  zero_level;
    logic [GAIN_W-1:0]  gain_q16;
    logic [SUM_W-1:0]   energy;
    logic [COUNT_W-1:0] taken;
    bit                 dropped;

    rms_result_t pending_rms[$];
    int  samples_sent;
    int  windows_checked;
    int  settings;
    int  faults;
    bit  calm;
    bit  hold_off_req;

    // expected result typed in only where it is obvious
    dir_row_t dir_table [DIR_ROWS] = '{
        '{ROW_ITEM, 12'd2048, 1'b1, 12'd0, 20'd0, 1'b1, '{12'd0, 16'd0, 13'd1, 1'b0}},
        '{ROW_ITEM, 12'd4095, 1'b1, 12'd0, 20'd0, 1'b1,
          '{12'd2047, 16'd2047, 13'd1, 1'b0}},
        '{ROW_ITEM, 12'd0, 1'b1, 12'd0, 20'd0, 1'b1, '{12'd2048, 16'd2048, 13'd1, 1'b0}},
        '{ROW_ITEM, 12'd0, 1'b0, 12'd0, 20'd0, 1'b0, '0},
        '{ROW_ITEM, 12'd4095, 1'b1, 12'd0, 20'd0, 1'b1,
          '{12'd2047, 16'd2047, 13'd2, 1'b0}},
        '{ROW_ITEM, 12'hAAA, 1'b0, 12'd0, 20'd0, 1'b0, '0},
        '{ROW_ITEM, 12'h555, 1'b0, 12'd0, 20'd0, 1'b0, '0},
        '{ROW_ITEM, 12'h800, 1'b0, 12'd0, 20'd0, 1'b0, '0},
        '{ROW_ITEM, 12'h7FF, 1'b1, 12'd0, 20'd0, 1'b0, '0},
        '{ROW_ITEM, 12'h001, 1'b0, 12'd0, 20'd0, 1'b0, '0},
        '{ROW_ITEM, 12'hFFE, 1'b1, 12'd0, 20'd0, 1'b0, '0},
        '{ROW_CFG,  12'd0, 1'b0, 12'd0, 20'hFFFFF, 1'b0, '0},
        '{ROW_ITEM, 12'd4095, 1'b1, 12'd0, 20'd0, 1'b1,
          '{12'd4095, 16'd65519, 13'd1, 1'b0}},
        '{ROW_ITEM, 12'd0, 1'b1, 12'd0, 20'd0, 1'b1, '{12'd0, 16'd0, 13'd1, 1'b0}},
        '{ROW_ITEM, 12'h123, 1'b0, 12'd0, 20'd0, 1'b0, '0},
        '{ROW_ITEM, 12'hEDC, 1'b1, 12'd0, 20'd0, 1'b0, '0},
        '{ROW_CFG,  12'd0, 1'b0, 12'hFFF, 20'h0, 1'b0, '0},
        '{ROW_ITEM, 12'd0, 1'b1, 12'd0, 20'd0, 1'b1, '{12'd4095, 16'd0, 13'd1, 1'b0}},
        '{ROW_ITEM, 12'd4095, 1'b1, 12'd0, 20'd0, 1'b1, '{12'd0, 16'd0, 13'd1, 1'b0}},
        '{ROW_ITEM, 12'h9C4, 1'b0, 12'd0, 20'd0, 1'b0, '0},
        '{ROW_ITEM, 12'h3B1, 1'b1, 12'd0, 20'd0, 1'b0, '0},
        '{ROW_CFG,  12'd0, 1'b0, 12'h5A5, 20'h08000, 1'b0, '0},
        '{ROW_ITEM, 12'h609, 1'b1, 12'd0, 20'd0, 1'b1, '{12'd100, 16'd50, 13'd1, 1'b0}},
        '{ROW_ITEM, 12'h0F0, 1'b0, 12'd0, 20'd0, 1'b0, '0},
        '{ROW_ITEM, 12'hF0F, 1'b1, 12'd0, 20'd0, 1'b0, '0}
    };

    windowed_rms_meter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [ROOT_W-1:0] int_sqrt(input longint unsigned v);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] t;
        longint unsigned   tt;
        r = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            t  = r | (ROOT_W'(1) << b);
            tt = t;
            if (tt * tt <= v)
                r = t;
        end
        return r;
    endfunction

    // one accepted sample; returns 1 with the window's result when it closes
    function automatic bit fold_sample(input logic [SAMPLE_BITS-1:0] s, input bit last,
                                       output rms_result_t res);
        int              d;
        longint unsigned mean;
        longint unsigned prod;
        res = '0;
        if (taken >= MAX_SAMPLES)
            dropped = 1'b1;
        else
        begin
            d      = int'(s) - int'(zero_level);
            energy = energy + SUM_W'(d * d);
            taken  = taken + 1'b1;
        end
        if (!last)
            return 1'b0;
        mean       = (taken != 0) ? energy / taken : 0;
        res.counts = int_sqrt(mean);
        prod       = res.counts;
        prod       = (prod * gain_q16) >> GAIN_FRAC;
        res.scaled = (prod > 64'hFFFF) ? 16'hFFFF : prod[SCALED_W-1:0];
        res.n      = taken;
        res.ovf    = dropped;
        energy     = '0;
        taken      = '0;
        dropped    = 1'b0;
        return 1'b1;
    endfunction

    // mostly short idles, now and then a long one
    function automatic int pick_pause();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 45)
            return SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
        if (r < 75)
        begin
            v = int'(zero_level) + $urandom_range(0, 128) - 64;
            if (v < 0)
                v = 0;
            if (v > FULL_SCALE)
                v = FULL_SCALE;
            return v[SAMPLE_BITS-1:0];
        end
        if (r < 88)
            return $urandom_range(0, 1) ? FULL_SCALE : '0;
        return zero_level;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, 40);
        return $urandom_range(41, 200);
    endfunction

    // tvalid is only touched once per time step
    task automatic offer_sample(input logic [SAMPLE_BITS-1:0] s, input bit last,
                                output rms_result_t res, output bit got);
        int pause;
        pause = pick_pause();
        if (pause > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(s);
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        got = fold_sample(s, last, res);
        samples_sent++;
    endtask

    task automatic feed(input logic [SAMPLE_BITS-1:0] s, input bit last);
        rms_result_t res;
        bit          got;
        offer_sample(s, last, res, got);
        if (got)
            pending_rms.push_back(res);
    endtask

    task automatic random_window(input int len);
        for (int i = 0; i < len; i++)
            feed(pick_sample(), i == len - 1);
    endtask

    // registers change only with every window closed and its result drained
    task automatic program_meter(input logic [OFFS_W-1:0] offs, input logic [GAIN_W-1:0] g);
        s_axis_tvalid <= 1'b0;
        while (pending_rms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ZERO_OFFSET;
        cfg_data  <= CFG_W'(offs);
        @(posedge clk);
        cfg_index <= CFG_VOLTS_GAIN;
        cfg_data  <= g;
        @(posedge clk);
        cfg_we     <= 1'b0;
        zero_level  = offs;
        gain_q16    = g;
        settings++;
    endtask

    // result checker
    always @(posedge clk)
    begin : check_result
        rms_result_t want;
        rms_result_t seen;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.counts = m_axis_tdata[ROOT_W-1:0];
            seen.scaled = m_axis_tdata[ROOT_W +: SCALED_W];
            seen.n      = m_axis_tdata[ROOT_W + SCALED_W +: COUNT_W];
            seen.ovf    = m_axis_tuser[0];
            if (pending_rms.size() == 0)
            begin
                $error("result with no window closed: rms_counts %0d", seen.counts);
                faults++;
            end
            else
            begin
                want = pending_rms.pop_front();
                if (seen.counts !== want.counts)
                begin
                    $error("rms_counts: expected %0d, got %0d", want.counts, seen.counts);
                    faults++;
                end
                if (seen.scaled !== want.scaled)
                begin
                    $error("rms_scaled: expected %0d, got %0d", want.scaled, seen.scaled);
                    faults++;
                end
                if (seen.n !== want.n)
                begin
                    $error("window_samples: expected %0d, got %0d", want.n, seen.n);
                    faults++;
                end
                if (seen.ovf !== want.ovf)
                begin
                    $error("count_overflow: expected %0d, got %0d", want.ovf, seen.ovf);
                    faults++;
                end
                windows_checked++;
            end
        end
    end

    // result side back-pressure, with one long hold-off on request
    initial
    begin : result_sink
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = pick_pause();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        rms_result_t res;
        bit          got;
        int          start;
        logic [OFFS_W-1:0] offs;
        logic [GAIN_W-1:0] g;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_ZERO_OFFSET;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        zero_level    = OFFSET_RESET;
        gain_q16      = GAIN_RESET;
        energy        = '0;
        taken         = '0;
        dropped       = 1'b0;
        calm          = 1'b0;
        hold_off_req  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_table[i].kind == ROW_CFG)
                program_meter(dir_table[i].offset, dir_table[i].gain);
            else
            begin
                offer_sample(dir_table[i].sample, dir_table[i].last, res, got);
                if (got)
                    pending_rms.push_back(dir_table[i].typed ? dir_table[i].want : res);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            offs = OFFS_W'($urandom_range(0, FULL_SCALE));
            g    = GAIN_W'($urandom_range(0, 20'hFFFFF));
            case (p)
                1: begin offs = '0;           g = '1;         end
                2: begin offs = '1;           g = '0;         end
                4: begin offs = OFFSET_RESET; g = GAIN_RESET; end
                5: g = GAIN_W'($urandom_range(0, 20'h0FFFF));
                default: ;
            endcase
            program_meter(offs, g);
            calm = (p == 3);
            // long result hold-off while samples keep coming
            if (p == 0)
                hold_off_req = 1'b1;
            start = samples_sent;
            while (samples_sent - start < PHASE_ITEMS)
                random_window(pick_len());
        end

        // one long window of mostly full-scale samples: square sum beyond 32 bits
        program_meter('0, GAIN_W'($urandom_range(0, 20'hFFFFF)));
        calm = 1'b1;
        for (int i = 0; i < WIDE_ITEMS; i++)
            feed(($urandom_range(0, 7) != 0) ? FULL_SCALE : pick_sample(), i == WIDE_ITEMS - 1);
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (pending_rms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d samples in %0d checked windows over %0d register settings",
                 samples_sent, windows_checked, settings);
        $display("covered a window summing past 32 bits and a %0d-cycle result hold-off",
                 HOLD_CYCLES);
        if (faults == 0)
            $display("tb_windowed_rms_meter: done, clean");
        else
            $display("tb_windowed_rms_meter: done, errors");
        $finish;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("tb_windowed_rms_meter: done, errors");
        $finish;
    end

endmodule
